// ----- sv/azpid_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants of the azimuth position PID loop.
package azpid_pkg;

	// Field widths
	localparam int ENC_W  = 12;
	localparam int DUTY_W = 16;
	localparam int GAIN_W = 32;
	localparam int STEP_W = 16;
	localparam int LIM_W  = 16;
	localparam int INT_W  = 48;

	// Revolution and PWM scaling; the revolution is 2**ENC_W counts
	localparam int COUNTS_PER_REV = 4096;
	localparam int PWM_FULL_COUNT = 65535;
	localparam int DEAD_BAND      = 5;

	// Datapath widths
	localparam int CALC_W  = ENC_W + 2;
	localparam int MUL_A_W = GAIN_W + 1;
	localparam int MUL_B_W = DUTY_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int FRAC_W  = 24;
	localparam int MAG_W   = FRAC_W;
	localparam int LIM_SH  = MAG_W - LIM_W;

	// APB
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	// Register reset values
	localparam logic [GAIN_W-1:0] GAIN_P_RST   = '0;
	localparam logic [GAIN_W-1:0] GAIN_D_RST   = '0;
	localparam logic [STEP_W-1:0] INT_STEP_RST = STEP_W'(336);
	localparam logic [LIM_W-1:0]  MAX_DUTY_RST = '1;
	localparam logic [LIM_W-1:0]  MIN_DUTY_RST = '0;

	// Register map, word index
	typedef enum logic [2:0] {
		REG_GAIN_P   = 3'd0,
		REG_GAIN_D   = 3'd1,
		REG_INT_STEP = 3'd2,
		REG_MAX_DUTY = 3'd3,
		REG_MIN_DUTY = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_d;
		logic [STEP_W-1:0] integral_step;
		logic [LIM_W-1:0]  max_duty;
		logic [LIM_W-1:0]  min_duty;
	} cfg_t;

	// Request to the shared multiplier
	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_I,
		ST_MUL_P,
		ST_MUL_D,
		ST_SUM,
		ST_ABS,
		ST_CLAMP,
		ST_MUL_PWM,
		ST_OUT
	} state_t;

endpackage

// ----- sv/azpid_ifs.sv -----
`timescale 1ns / 1ps
// Request channels of the azimuth position PID loop: tick in, PWM command out.
interface azpid_tick_if;
	logic                       valid;
	logic                       ready;
	logic [azpid_pkg::ENC_W-1:0] encoder_count;
	logic [azpid_pkg::ENC_W-1:0] target_count;
	logic                       motor_enable;

	modport source (output valid, output encoder_count, output target_count,
		output motor_enable, input ready);
	modport sink (input valid, input encoder_count, input target_count,
		input motor_enable, output ready);
endinterface

interface azpid_pwm_if;
	logic                        valid;
	logic                        ready;
	logic [azpid_pkg::DUTY_W-1:0] duty_count;
	logic                        drive_forward;

	modport source (output valid, output duty_count, output drive_forward, input ready);
	modport sink (input valid, input duty_count, input drive_forward, output ready);
endinterface

// ----- sv/azpid_regs.sv -----
`timescale 1ns / 1ps
// APB configuration registers of the azimuth position PID loop.
module azpid_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [azpid_pkg::ADDR_W-1:0] paddr,
	input  logic [azpid_pkg::DATA_W-1:0] pwdata,
	output logic [azpid_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	output azpid_pkg::cfg_t              cfg
);

	azpid_pkg::cfg_t cfg_q;
	logic            wr_en;
	logic [2:0]      idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[azpid_pkg::ADDR_W-1:2];
	assign cfg    = cfg_q;

	// Register writes; unmapped words are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p        <= azpid_pkg::GAIN_P_RST;
			cfg_q.gain_d        <= azpid_pkg::GAIN_D_RST;
			cfg_q.integral_step <= azpid_pkg::INT_STEP_RST;
			cfg_q.max_duty      <= azpid_pkg::MAX_DUTY_RST;
			cfg_q.min_duty      <= azpid_pkg::MIN_DUTY_RST;
		end else if (wr_en) begin
			case (idx)
				azpid_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= pwdata[azpid_pkg::GAIN_W-1:0];
				end
				azpid_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= pwdata[azpid_pkg::GAIN_W-1:0];
				end
				azpid_pkg::REG_INT_STEP: begin
					cfg_q.integral_step <= pwdata[azpid_pkg::STEP_W-1:0];
				end
				azpid_pkg::REG_MAX_DUTY: begin
					cfg_q.max_duty <= pwdata[azpid_pkg::LIM_W-1:0];
				end
				azpid_pkg::REG_MIN_DUTY: begin
					cfg_q.min_duty <= pwdata[azpid_pkg::LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read-back
	always_comb begin
		case (idx)
			azpid_pkg::REG_GAIN_P:   prdata = azpid_pkg::DATA_W'(cfg_q.gain_p);
			azpid_pkg::REG_GAIN_D:   prdata = azpid_pkg::DATA_W'(cfg_q.gain_d);
			azpid_pkg::REG_INT_STEP: prdata = azpid_pkg::DATA_W'(cfg_q.integral_step);
			azpid_pkg::REG_MAX_DUTY: prdata = azpid_pkg::DATA_W'(cfg_q.max_duty);
			azpid_pkg::REG_MIN_DUTY: prdata = azpid_pkg::DATA_W'(cfg_q.min_duty);
			default:                 prdata = '0;
		endcase
	end

endmodule

// ----- sv/azpid_mul.sv -----
`timescale 1ns / 1ps
// Shared signed 33x17 multiplier with registered product.
module azpid_mul (
	input  logic                                clk,
	input  azpid_pkg::mul_req_t                 req,
	output logic signed [azpid_pkg::PROD_W-1:0] prod_q
);

	logic signed [azpid_pkg::PROD_W-1:0] prod;

	assign prod = azpid_pkg::PROD_W'(req.a) * azpid_pkg::PROD_W'(req.b);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= prod;
		end
	end

endmodule

// ----- sv/azpid_seq.sv -----
`timescale 1ns / 1ps
// Sequencer and datapath: speed, distance, integral, drive sum, clamp, output.
module azpid_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  azpid_pkg::cfg_t                     cfg,
	azpid_tick_if.sink                          tick,
	azpid_pwm_if.source                         pwm,
	output azpid_pkg::mul_req_t                 mul_req,
	input  logic signed [azpid_pkg::PROD_W-1:0] prod
);

	localparam int CW = azpid_pkg::CALC_W;
	localparam int PW = azpid_pkg::PROD_W;
	localparam int IW = azpid_pkg::INT_W;
	localparam int MW = azpid_pkg::MAG_W;
	localparam logic signed [CW-1:0] REV  = CW'(azpid_pkg::COUNTS_PER_REV);
	localparam logic signed [CW-1:0] NEAR = CW'(azpid_pkg::COUNTS_PER_REV / 4);
	localparam logic signed [CW-1:0] HALF = CW'(azpid_pkg::COUNTS_PER_REV / 2);
	localparam logic signed [CW-1:0] MIND = CW'(azpid_pkg::DEAD_BAND);
	localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};

	azpid_pkg::state_t state_q, state_d;

	// Tick payload and loop state
	logic [azpid_pkg::ENC_W-1:0] enc_q, targ_q, last_q;
	logic                        en_q;
	logic signed [IW-1:0]        integ_q;
	logic signed [CW-1:0]        speed_q, dist_q;
	logic                        integ_upd_q;
	logic signed [PW-1:0]        acc_q;
	logic [PW-1:0]               mag_q;
	logic                        neg_q;
	logic [MW-1:0]               capped_q;

	// Output register
	logic                          out_valid_q;
	logic [azpid_pkg::DUTY_W-1:0]  duty_q;
	logic                          fwd_q;
	logic                          out_load;

	// Speed and shortest distance; counts span the full 2**ENC_W revolution
	logic signed [CW-1:0] cur_s, old_s, targ_s, diff, spd_c, dist_c;
	logic                 integ_upd_c;

	always_comb begin
		cur_s  = signed'(CW'(enc_q));
		old_s  = signed'(CW'(last_q));
		targ_s = signed'(CW'(targ_q));
		if (old_s > REV - NEAR && cur_s < NEAR) begin
			spd_c = (REV - old_s) + cur_s;
		end else if (cur_s > REV - NEAR && old_s < NEAR) begin
			spd_c = cur_s - (old_s + REV);
		end else begin
			spd_c = cur_s - old_s;
		end
		diff = targ_s - cur_s;
		if (diff > HALF) begin
			dist_c = diff - REV;
		end else if (diff < -HALF) begin
			dist_c = diff + REV;
		end else begin
			dist_c = diff;
		end
		integ_upd_c = (dist_c > MIND || dist_c < -MIND) && (spd_c == '0);
	end

	// Saturating integral add
	logic signed [IW:0]   int_sum;
	logic signed [IW-1:0] int_next;

	always_comb begin
		int_sum = signed'({integ_q[IW-1], integ_q}) + signed'(prod[IW:0]);
		if (int_sum[IW] != int_sum[IW-1]) begin
			int_next = int_sum[IW] ? INT_MIN : INT_MAX;
		end else begin
			int_next = int_sum[IW-1:0];
		end
	end

	// Clamp and dead band
	logic [MW-1:0] cap, floor_lim, clamp_c;

	always_comb begin
		cap       = {cfg.max_duty, {azpid_pkg::LIM_SH{1'b0}}};
		floor_lim = {cfg.min_duty, {azpid_pkg::LIM_SH{1'b0}}};
		clamp_c   = (mag_q > PW'(cap)) ? cap : mag_q[MW-1:0];
		if (clamp_c <= floor_lim) begin
			clamp_c = '0;
		end
	end

	// Next state, handshakes and multiplier operands
	always_comb begin
		state_d    = state_q;
		tick.ready = 1'b0;
		out_load   = 1'b0;
		mul_req.en = 1'b0;
		mul_req.a  = '0;
		mul_req.b  = '0;
		case (state_q)
			azpid_pkg::ST_IDLE: begin
				tick.ready = 1'b1;
				if (tick.valid) begin
					state_d = azpid_pkg::ST_PREP;
				end
			end
			azpid_pkg::ST_PREP: state_d = azpid_pkg::ST_MUL_I;
			azpid_pkg::ST_MUL_I: begin
				mul_req.en = 1'b1;
				mul_req.a  = signed'(azpid_pkg::MUL_A_W'(cfg.integral_step));
				mul_req.b  = azpid_pkg::MUL_B_W'(dist_q);
				state_d    = azpid_pkg::ST_MUL_P;
			end
			azpid_pkg::ST_MUL_P: begin
				mul_req.en = 1'b1;
				mul_req.a  = signed'(azpid_pkg::MUL_A_W'(cfg.gain_p));
				mul_req.b  = azpid_pkg::MUL_B_W'(dist_q);
				state_d    = azpid_pkg::ST_MUL_D;
			end
			azpid_pkg::ST_MUL_D: begin
				mul_req.en = 1'b1;
				mul_req.a  = signed'(azpid_pkg::MUL_A_W'(cfg.gain_d));
				mul_req.b  = azpid_pkg::MUL_B_W'(speed_q);
				state_d    = azpid_pkg::ST_SUM;
			end
			azpid_pkg::ST_SUM:   state_d = azpid_pkg::ST_ABS;
			azpid_pkg::ST_ABS:   state_d = azpid_pkg::ST_CLAMP;
			azpid_pkg::ST_CLAMP: state_d = azpid_pkg::ST_MUL_PWM;
			azpid_pkg::ST_MUL_PWM: begin
				mul_req.en = 1'b1;
				mul_req.a  = signed'(azpid_pkg::MUL_A_W'(capped_q));
				mul_req.b  = signed'(azpid_pkg::MUL_B_W'(azpid_pkg::PWM_FULL_COUNT));
				state_d    = azpid_pkg::ST_OUT;
			end
			azpid_pkg::ST_OUT: begin
				// wait here while a previous result is still held
				if (!out_valid_q || pwm.ready) begin
					out_load = 1'b1;
					state_d  = azpid_pkg::ST_IDLE;
				end
			end
			default: state_d = azpid_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= azpid_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Loop state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == azpid_pkg::ST_PREP) begin
				last_q <= enc_q;
			end
			if (state_q == azpid_pkg::ST_MUL_P) begin
				integ_q <= integ_upd_q ? int_next : '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pwm.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			azpid_pkg::ST_IDLE: begin
				if (tick.valid) begin
					enc_q  <= tick.encoder_count;
					targ_q <= tick.target_count;
					en_q   <= tick.motor_enable;
				end
			end
			azpid_pkg::ST_PREP: begin
				speed_q     <= spd_c;
				dist_q      <= dist_c;
				integ_upd_q <= integ_upd_c;
			end
			// P product plus the fresh integral
			azpid_pkg::ST_MUL_D: acc_q <= prod + PW'(integ_q);
			// minus the D product
			azpid_pkg::ST_SUM: acc_q <= acc_q - prod;
			azpid_pkg::ST_ABS: begin
				if (!en_q) begin
					neg_q <= 1'b0;
					mag_q <= '0;
				end else begin
					neg_q <= acc_q[PW-1];
					mag_q <= acc_q[PW-1] ? unsigned'(-acc_q) : unsigned'(acc_q);
				end
			end
			azpid_pkg::ST_CLAMP: capped_q <= clamp_c;
			azpid_pkg::ST_OUT: begin
				if (out_load) begin
					duty_q <= prod[azpid_pkg::FRAC_W +: azpid_pkg::DUTY_W];
					fwd_q  <= !neg_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign pwm.valid         = out_valid_q;
	assign pwm.duty_count    = duty_q;
	assign pwm.drive_forward = fwd_q;

endmodule

// ----- sv/azimuth_position_pid_loop_top.sv -----
`timescale 1ns / 1ps
// Top level of the azimuth position PID loop.
//
// One tick request carries the encoder count, target count and enable; it
// returns one PWM request (duty_count, drive_forward). A tick is taken only
// once the previous one is through: ready returns together with the result.
// A small sequencer steps through speed and distance, then four
// multiplications (integral step, P, D, PWM scaling) that all share one
// registered 33x17 signed multiplier, with the saturating integral, drive sum,
// magnitude and duty clamp in between. The result is held in an output
// register; if an earlier result has not been taken, the sequencer waits
// before loading it, and ready stays low for as long as it waits.
// ready is low while a tick is in work. Registers are written over APB at
// byte address 4*index and should only be written while the block is idle.
module azimuth_position_pid_loop_top (
	input  logic                         clk,
	input  logic                         arst_n,
	azpid_tick_if.sink                   tick,
	azpid_pwm_if.source                  pwm,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [azpid_pkg::ADDR_W-1:0] paddr,
	input  logic [azpid_pkg::DATA_W-1:0] pwdata,
	output logic [azpid_pkg::DATA_W-1:0] prdata,
	output logic                         pready
);

	azpid_pkg::cfg_t                     cfg;
	azpid_pkg::mul_req_t                 mul_req;
	logic signed [azpid_pkg::PROD_W-1:0] prod;

	azpid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	azpid_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod)
	);

	azpid_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.tick    (tick),
		.pwm     (pwm),
		.mul_req (mul_req),
		.prod    (prod)
	);

endmodule

// ----- sv/azpid_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the azimuth position PID loop, bound to the top level.
module azpid_port_props (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         tick_valid,
	input logic                         tick_ready,
	input logic                         pwm_valid,
	input logic                         pwm_ready,
	input logic [azpid_pkg::DUTY_W-1:0] duty_count,
	input logic                         drive_forward
);

	// A tick in work holds off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("tick ready right after an accepted tick");

	// A new result comes only at the end of a tick in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pwm_valid) |-> $past(!tick_ready))
		else $error("result appeared while no tick was in work");

	// No result in the cycle after a tick is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !$rose(pwm_valid))
		else $error("result appeared right after acceptance");

	// A stalled result holds
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_valid && !pwm_ready |=> pwm_valid && $stable(duty_count)
			&& $stable(drive_forward))
		else $error("stalled result changed");

endmodule

bind azimuth_position_pid_loop_top azpid_port_props u_azpid_port_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.tick_valid    (tick.valid),
	.tick_ready    (tick.ready),
	.pwm_valid     (pwm.valid),
	.pwm_ready     (pwm.ready),
	.duty_count    (pwm.duty_count),
	.drive_forward (pwm.drive_forward)
);

// ----- tb/azpid_checker.sv -----
`timescale 1ns / 1ps
// Checker for the azimuth position PID loop: predicts every PWM request and compares.
module azpid_checker
	import azpid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	azpid_tick_if             tick,
	azpid_pwm_if              pwm,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                fails,
	output int                pending
);

	localparam int REV  = COUNTS_PER_REV;
	localparam int QREV = REV / 4;
	localparam int HALF = REV / 2;
	localparam longint INT_HI = (longint'(1) <<< (INT_W - 1)) - 1;
	localparam longint INT_LO = -(longint'(1) <<< (INT_W - 1));

	typedef struct packed {
		logic [DUTY_W-1:0] duty_count;
		logic              drive_forward;
	} pwm_cmd_t;

	// Shadow of the register file, taken from observed APB writes
	logic [GAIN_W-1:0] kp;
	logic [GAIN_W-1:0] kd;
	logic [STEP_W-1:0] ki_step;
	logic [LIM_W-1:0]  duty_hi;
	logic [LIM_W-1:0]  duty_lo;

	// Loop state
	logic [ENC_W-1:0] prev_pos;
	longint           integ;

	pwm_cmd_t cmd_q[$];

	// One control tick: speed, shortest distance, integral, drive, duty
	function automatic pwm_cmd_t pid_tick(input logic [ENC_W-1:0] enc,
			input logic [ENC_W-1:0] targ, input logic en);
		int cur, old, spd, err, abs_err;
		longint acc, drv;
		longint unsigned mag, cap, floor_lim, duty;
		pwm_cmd_t c;
		cur = enc;
		old = prev_pos;
		prev_pos = enc;

		// speed, unwrapped when the count crosses zero
		if (old > REV - QREV && cur < QREV)
			spd = (REV - old) + cur;
		else if (cur > REV - QREV && old < QREV)
			spd = cur - (old + REV);
		else
			spd = cur - old;

		err = int'(targ) - cur;
		if (err > HALF)
			err = err - REV;
		else if (err < -HALF)
			err = err + REV;
		abs_err = (err < 0) ? -err : err;

		// integral builds only while stalled away from target
		if (abs_err > DEAD_BAND && spd == 0) begin
			acc = integ + longint'({48'd0, ki_step}) * err;
			if (acc > INT_HI)
				acc = INT_HI;
			if (acc < INT_LO)
				acc = INT_LO;
			integ = acc;
		end else begin
			integ = 0;
		end

		drv = 0;
		if (en)
			drv = longint'({32'd0, kp}) * err - longint'({32'd0, kd}) * spd + integ;

		mag = (drv < 0) ? -drv : drv;
		cap = {48'd0, duty_hi} << LIM_SH;
		floor_lim = {48'd0, duty_lo} << LIM_SH;
		if (mag > cap)
			mag = cap;
		if (mag <= floor_lim)
			mag = 0;
		duty = (mag * 64'(PWM_FULL_COUNT)) >> FRAC_W;

		c.duty_count = duty[DUTY_W-1:0];
		c.drive_forward = (drv >= 0);
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pwm_cmd_t want;
		if (!arst_n) begin
			kp = GAIN_P_RST;
			kd = GAIN_D_RST;
			ki_step = INT_STEP_RST;
			duty_hi = MAX_DUTY_RST;
			duty_lo = MIN_DUTY_RST;
			prev_pos = '0;
			integ = 0;
			cmd_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			// register writes; unmapped words are dropped
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_GAIN_P:   kp = pwdata[GAIN_W-1:0];
					REG_GAIN_D:   kd = pwdata[GAIN_W-1:0];
					REG_INT_STEP: ki_step = pwdata[STEP_W-1:0];
					REG_MAX_DUTY: duty_hi = pwdata[LIM_W-1:0];
					REG_MIN_DUTY: duty_lo = pwdata[LIM_W-1:0];
					default: ;
				endcase
			end

			// PWM request out: compare with the oldest prediction
			if (pwm.valid && pwm.ready) begin
				if (cmd_q.size() == 0) begin
					$error("PWM request with no tick outstanding: duty_count %0d",
						pwm.duty_count);
					fails++;
				end else begin
					want = cmd_q.pop_front();
					if (pwm.duty_count !== want.duty_count) begin
						$error("duty_count: expected %0d, actual %0d",
							want.duty_count, pwm.duty_count);
						fails++;
					end
					if (pwm.drive_forward !== want.drive_forward) begin
						$error("drive_forward: expected %0d, actual %0d",
							want.drive_forward, pwm.drive_forward);
						fails++;
					end
				end
			end

			// tick request in
			if (tick.valid && tick.ready)
				cmd_q.push_back(pid_tick(tick.encoder_count, tick.target_count,
					tick.motor_enable));

			pending = cmd_q.size();
		end
	end

endmodule

// ----- tb/tb_azimuth_position_pid_loop_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the azimuth position PID loop: stimulus, APB setup and verdict.
module tb_azimuth_position_pid_loop_top;
	import azpid_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int TIMEOUT_CYCLES = 100000;
	localparam int LONG_HOLD      = 160;
	localparam int PHASES         = 8;
	localparam int PHASE_TICKS    = 85;
	localparam int REV            = COUNTS_PER_REV;
	localparam int QREV           = REV / 4;
	localparam logic [2:0] SPARE_IDX = 3'd5; // unmapped register word

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic              pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	int                fails;
	int                pending;
	bit                quiet;
	bit                hold_req;
	int                pos;
	int                tgt;

	azpid_tick_if tick_ch();
	azpid_pwm_if  pwm_ch();

	azimuth_position_pid_loop_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.pwm     (pwm_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	azpid_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.pwm     (pwm_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Regression FAIL");
		$finish;
	end

	// APB write: setup cycle, then access cycle until pready
	task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
			input logic [STEP_W-1:0] step, input logic [LIM_W-1:0] hi,
			input logic [LIM_W-1:0] lo);
		apb_write(REG_GAIN_P, DATA_W'(kp));
		apb_write(REG_GAIN_D, DATA_W'(kd));
		apb_write(REG_INT_STEP, DATA_W'(step));
		apb_write(REG_MAX_DUTY, DATA_W'(hi));
		apb_write(REG_MIN_DUTY, DATA_W'(lo));
	endtask

	// Offer one tick request, hold it until taken, then maybe go idle a while
	task automatic send_tick(input int enc, input int targ, input bit en);
		int gap;
		tick_ch.valid <= 1'b1;
		tick_ch.encoder_count <= enc[ENC_W-1:0];
		tick_ch.target_count <= targ[ENC_W-1:0];
		tick_ch.motor_enable <= en;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			tick_ch.valid <= 1'b0;
			tick_ch.encoder_count <= ENC_W'($urandom());
			tick_ch.target_count <= ENC_W'($urandom());
			tick_ch.motor_enable <= 1'($urandom());
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted request has come out
	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom() >> $urandom_range(6, 22);
		endcase
	endfunction

	// PWM side: random back-pressure, one long hold on request
	initial begin
		pwm_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				pwm_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				pwm_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				pwm_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : stim
		logic [GAIN_W-1:0] gp, gd;
		logic [STEP_W-1:0] st;
		logic [LIM_W-1:0]  hi, lo;
		int r;
		bit en;

		quiet = 1'b0;
		hold_req = 1'b0;
		pos = 0;
		tgt = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.encoder_count <= '0;
		tick_ch.target_count <= '0;
		tick_ch.motor_enable <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: integral only, default step
		send_tick(100, 200, 1'b1);
		send_tick(100, 200, 1'b1);
		send_tick(100, 200, 1'b1);
		wait_drained();

		load_settings(32'h0001_0000, 32'h0004_0000, 16'hFFFF, 16'hC000, 16'h0100);
		apb_write(SPARE_IDX, '1);

		// distance at and beyond half a revolution, wrap of both counts
		send_tick(0, 0, 1'b1);
		send_tick(0, 4095, 1'b1);
		send_tick(4095, 0, 1'b1);
		send_tick(0, 2048, 1'b1);
		send_tick(0, 2049, 1'b1);
		send_tick(4095, 2047, 1'b1);
		send_tick(4095, 2046, 1'b1);
		// stalled just outside and at the dead band
		send_tick(100, 106, 1'b1);
		send_tick(100, 106, 1'b1);
		send_tick(100, 106, 1'b1);
		send_tick(100, 105, 1'b1);
		send_tick(100, 94, 1'b1);
		send_tick(100, 94, 1'b1);
		// disabled while the integral keeps building
		send_tick(100, 200, 1'b0);
		send_tick(100, 200, 1'b0);
		send_tick(100, 200, 1'b1);
		// speed wrap thresholds on either side of the quarter bands
		send_tick(3073, 3073, 1'b1);
		send_tick(1023, 1023, 1'b1);
		send_tick(3072, 0, 1'b1);
		send_tick(0, 0, 1'b1);
		send_tick(4095, 4095, 1'b1);
		send_tick(2048, 0, 1'b1);
		wait_drained();
		pos = 2048;
		tgt = 0;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: load_settings('1, '1, '1, '1, '0);
				1: load_settings('0, '0, '0, '0, '1);
				default: begin
					gp = pick_gain();
					gd = pick_gain();
					r = $urandom_range(0, 9);
					st = (r < 2) ? '1 : (r < 3) ? '0 : LIM_W'($urandom());
					r = $urandom_range(0, 9);
					hi = (r < 1) ? '0 : (r < 4) ? '1 : LIM_W'($urandom());
					r = $urandom_range(0, 9);
					lo = (r < 5) ? '0 : (r < 9) ? LIM_W'($urandom_range(0, 2048)) :
						LIM_W'($urandom());
					load_settings(gp, gd, st, hi, lo);
				end
			endcase
			quiet = (ph == PHASES - 1);

			for (int n = 0; n < PHASE_TICKS; n++) begin
				if (ph == 3 && n == 10)
					hold_req = 1'b1;
				if (ph == 4 && n == 40)
					wait_drained();

				// shaft motion: mostly still or creeping, sometimes a jump
				r = $urandom_range(0, 99);
				if (r >= 35 && r < 75)
					pos = (pos + int'($urandom_range(0, 48)) - 24 + REV) % REV;
				else if (r >= 75 && r < 85)
					pos = $urandom_range(0, REV - 1);
				else if (r >= 85 && r < 93)
					pos = $urandom_range(0, 1) ? int'($urandom_range(REV - QREV - 16, REV - 1))
						: int'($urandom_range(0, QREV + 16));

				// target: held, re-aimed, or parked near the dead band
				r = $urandom_range(0, 99);
				if (r < 8)
					tgt = $urandom_range(0, REV - 1);
				else if (r < 14)
					tgt = (pos + int'($urandom_range(0, 14)) - 7 + REV) % REV;

				en = ($urandom_range(0, 11) != 0);
				send_tick(pos, tgt, en);
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
